FILE: sv/ncv_pkg.sv
// Shared constants and codes for the normalized 2D convolution unit.
`default_nettype none
package ncv_pkg;

  localparam int KERNEL_SIZE_DEFAULT = 3;
  localparam int MAX_LINE_DEFAULT    = 1024;

  localparam int OP_W        = 2;
  localparam int PIX_W       = 8;
  localparam int COEF_IDX_W  = 4;
  localparam int COEF_W      = 18;
  localparam int SIZE_W      = 11;
  localparam int RECIP_W     = 32;
  localparam int ROW_W       = SIZE_W + 1;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int FRAC_BITS   = 28;
  localparam int TERM_W      = PIX_W + 1 + COEF_W;

  localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;

  localparam logic [OP_W-1:0] OP_COEF  = 2'd0;
  localparam logic [OP_W-1:0] OP_PIXEL = 2'd1;
  localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_RECIP  = 2'd2;

endpackage
`default_nettype wire

FILE: sv/ncv_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module ncv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: sv/normalized_2d_convolution_unit.sv
// Top level of the normalized KxK convolution unit with a ring of line stores in RAM.
// A result passes the read, drain, low and high multiply, sum and emit states after its word.
// No new word is taken until the result is emitted; the window needs one RAM read per tap.
// Words that yield no result (coefficient loads, dropped pixels) leave the unit idle.
// Synchronous reset clears positions, coefficients, settings and valid flags, not the line RAM.
`default_nettype none
module normalized_2d_convolution_unit
  import ncv_pkg::*;
#(
  parameter int KERNEL_SIZE = KERNEL_SIZE_DEFAULT,
  parameter int MAX_LINE    = MAX_LINE_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic        [OP_W-1:0]       op,
  input  wire logic        [PIX_W-1:0]      pixel_in,
  input  wire logic        [COEF_IDX_W-1:0] coef_index,
  input  wire logic signed [COEF_W-1:0]     coef_value,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic             [PIX_W-1:0]      pixel_out,
  output logic                              out_last,
  input  wire logic                         cfg_we,
  input  wire logic        [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic        [CFG_DATA_W-1:0] cfg_data
);

  localparam int HALF    = KERNEL_SIZE / 2;
  localparam int TAPS    = KERNEL_SIZE * KERNEL_SIZE;
  localparam int RING    = 2 * KERNEL_SIZE;
  localparam int DEPTH   = RING * MAX_LINE;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int COL_W   = $clog2(MAX_LINE);
  localparam int LEN_W   = $clog2(MAX_LINE + 1);
  localparam int POS_W   = LEN_W + 1;
  localparam int SLOT_W  = $clog2(RING);
  localparam int TAP_W   = $clog2(TAPS);
  localparam int KC_W    = $clog2(KERNEL_SIZE);
  localparam int LAG_W   = $clog2(HALF * MAX_LINE + HALF + 2);
  localparam int ACC_W   = TERM_W + $clog2(TAPS);
  localparam int PRODW   = ACC_W + RECIP_W;
  localparam int RW      = ROW_W + 2;
  localparam int CW      = LEN_W + 2;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_READ   = 7'b0000010,
    S_DRAIN  = 7'b0000100,
    S_MUL_LO = 7'b0001000,
    S_MUL_HI = 7'b0010000,
    S_SUM    = 7'b0100000,
    S_EMIT   = 7'b1000000
  } state_t;

  state_t state;

  logic        [SIZE_W-1:0]  line_length;
  logic        [SIZE_W-1:0]  line_count;
  logic signed [RECIP_W-1:0] norm_recip;
  logic signed [COEF_W-1:0]  coef_table [TAPS];

  logic [ROW_W-1:0]  in_row, out_row, wrow;
  logic [COL_W-1:0]  in_col, out_col, wcol;
  logic [SLOT_W-1:0] in_slot, out_slot, rd_slot;
  logic [LAG_W-1:0]  lag;
  logic              wlast;

  logic [KC_W-1:0]   rd_dr, rd_dc;
  logic [TAP_W-1:0]  rd_tap;
  logic              v1, live1, v2;
  logic signed [COEF_W-1:0]  coef1;
  logic signed [TERM_W-1:0]  term2;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W+16:0]  plo;
  logic signed [ACC_W+15:0]  phi;
  logic signed [PRODW-1:0]   prod;

  logic [LEN_W-1:0]  eff_len;
  logic [ROW_W-1:0]  eff_cnt;
  logic              in_done;
  logic [LAG_W-1:0]  lag_inc, thr;
  logic              accepted, emit_start, out_free, out_is_last;
  logic              in_wrap, out_wrap, ram_we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [PIX_W-1:0]  rdata;
  logic signed [RW-1:0] sr;
  logic signed [CW-1:0] sc;
  logic              live0;
  logic [PIX_W-1:0]  byte_val;
  logic [SLOT_W:0]   start_slot;

  always_comb begin
    if (line_length == '0) begin
      eff_len = LEN_W'(1);
    end else if (32'(line_length) > MAX_LINE) begin
      eff_len = LEN_W'(MAX_LINE);
    end else begin
      eff_len = LEN_W'(line_length);
    end
    eff_cnt = (line_count == '0) ? ROW_W'(1) : ROW_W'(line_count);
  end

  assign in_done  = in_row >= eff_cnt;
  assign lag_inc  = lag + LAG_W'(1);
  assign thr      = LAG_W'(LAG_W'(HALF) * LAG_W'(eff_len) + LAG_W'(HALF));
  assign in_ready = (state == S_IDLE);
  assign accepted = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign in_wrap  = POS_W'(in_col) + POS_W'(1) >= POS_W'(eff_len);
  assign out_wrap = POS_W'(out_col) + POS_W'(1) >= POS_W'(eff_len);
  assign out_is_last = out_wrap && (out_row + ROW_W'(1) >= eff_cnt);

  always_comb begin
    emit_start = 1'b0;
    ram_we     = 1'b0;
    if (accepted) begin
      case (op)
        OP_PIXEL: begin
          ram_we     = !in_done;
          emit_start = !in_done && (lag_inc > thr);
        end
        OP_FLUSH: begin
          emit_start = in_done;
        end
        default: begin
          emit_start = 1'b0;
        end
      endcase
    end
  end

  assign waddr = ADDR_W'(ADDR_W'(in_slot) * ADDR_W'(MAX_LINE)) + ADDR_W'(in_col);

  assign start_slot = (out_slot >= SLOT_W'(HALF)) ?
                      ((SLOT_W + 1)'(out_slot) - (SLOT_W + 1)'(HALF)) :
                      ((SLOT_W + 1)'(out_slot) + (SLOT_W + 1)'(RING - HALF));

  assign sr = $signed(RW'(wrow)) + $signed(RW'(rd_dr)) - $signed(RW'(HALF));
  assign sc = $signed(CW'(wcol)) + $signed(CW'(rd_dc)) - $signed(CW'(HALF));
  assign live0 = (sr >= 0) && (sr < $signed(RW'(eff_cnt))) &&
                 (sc >= 0) && (sc < $signed(CW'(eff_len)));
  assign raddr = ADDR_W'(ADDR_W'(rd_slot) * ADDR_W'(MAX_LINE)) + ADDR_W'(sc[COL_W-1:0]);

  ncv_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (waddr),
    .wdata (pixel_in),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    if (prod[PRODW-1]) begin
      byte_val = '0;
    end else if (|prod[PRODW-2:FRAC_BITS+PIX_W]) begin
      byte_val = PIX_MAX;
    end else begin
      byte_val = prod[FRAC_BITS+PIX_W-1:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      line_length <= SIZE_W'(1024);
      line_count  <= SIZE_W'(1024);
      norm_recip  <= RECIP_W'(65536);
      for (int i = 0; i < TAPS; i++) begin
        coef_table[i] <= '0;
      end
      in_row    <= '0;
      in_col    <= '0;
      in_slot   <= '0;
      out_row   <= '0;
      out_col   <= '0;
      out_slot  <= '0;
      lag       <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_EMIT) begin
        out_valid <= 1'b0;
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_LINE_LENGTH: begin
            line_length <= cfg_data[SIZE_W-1:0];
          end
          REG_LINE_COUNT: begin
            line_count <= cfg_data[SIZE_W-1:0];
          end
          REG_NORM_RECIP: begin
            norm_recip <= $signed(cfg_data[RECIP_W-1:0]);
          end
          default: begin
          end
        endcase
        if (cfg_index == REG_LINE_LENGTH || cfg_index == REG_LINE_COUNT) begin
          in_row   <= '0;
          in_col   <= '0;
          in_slot  <= '0;
          out_row  <= '0;
          out_col  <= '0;
          out_slot <= '0;
          lag      <= '0;
        end
      end

      if (accepted && op == OP_COEF && 32'(coef_index) < TAPS) begin
        coef_table[TAP_W'(coef_index)] <= coef_value;
      end

      if (ram_we) begin
        if (in_wrap) begin
          in_col  <= '0;
          in_row  <= in_row + ROW_W'(1);
          in_slot <= (in_slot == SLOT_W'(RING - 1)) ? '0 : in_slot + SLOT_W'(1);
        end else begin
          in_col <= in_col + COL_W'(1);
        end
        if (!emit_start) begin
          lag <= lag_inc;
        end
      end

      if (emit_start) begin
        wrow    <= out_row;
        wcol    <= out_col;
        wlast   <= out_is_last;
        rd_slot <= SLOT_W'(start_slot);
        rd_dr   <= '0;
        rd_dc   <= '0;
        rd_tap  <= '0;
        acc     <= '0;
        state   <= S_READ;
        if (out_is_last) begin
          in_row   <= '0;
          in_col   <= '0;
          in_slot  <= '0;
          out_row  <= '0;
          out_col  <= '0;
          out_slot <= '0;
          lag      <= '0;
        end else if (out_wrap) begin
          out_col  <= '0;
          out_row  <= out_row + ROW_W'(1);
          out_slot <= (out_slot == SLOT_W'(RING - 1)) ? '0 : out_slot + SLOT_W'(1);
        end else begin
          out_col <= out_col + COL_W'(1);
        end
      end

      v1 <= (state == S_READ);
      v2 <= v1;
      if (state == S_READ) begin
        live1 <= live0;
        coef1 <= coef_table[rd_tap];
      end
      if (v1) begin
        term2 <= $signed({1'b0, live1 ? rdata : PIX_W'(0)}) * coef1;
      end
      if (v2) begin
        acc <= acc + ACC_W'(term2);
      end

      case (state)
        S_READ: begin
          rd_tap <= rd_tap + TAP_W'(1);
          if (rd_dc == KC_W'(KERNEL_SIZE - 1)) begin
            rd_dc   <= '0;
            rd_dr   <= rd_dr + KC_W'(1);
            rd_slot <= (rd_slot == SLOT_W'(RING - 1)) ? '0 : rd_slot + SLOT_W'(1);
          end else begin
            rd_dc <= rd_dc + KC_W'(1);
          end
          if (rd_tap == TAP_W'(TAPS - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!v1 && !v2) begin
            state <= S_MUL_LO;
          end
        end
        S_MUL_LO: begin
          plo   <= acc * $signed({1'b0, norm_recip[15:0]});
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          phi   <= acc * $signed(norm_recip[31:16]);
          state <= S_SUM;
        end
        S_SUM: begin
          prod  <= (PRODW'(phi) <<< 16) + PRODW'(plo);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            pixel_out <= byte_val;
            out_last  <= wlast;
            state     <= S_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_state_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state register is not one-hot");

  a_pipe_in_window: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (state == S_READ || state == S_DRAIN))
    else $error("tap product valid outside the window read");

  a_lag_bound: assert property (@(posedge clk) disable iff (rst) lag <= thr)
    else $error("input lead over output exceeds the window reach");

  a_row_bound: assert property (@(posedge clk) disable iff (rst) in_row <= eff_cnt)
    else $error("input row beyond the frame");

  a_no_ram_write_busy: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == S_IDLE)
    else $error("line store written while a window is being read");
`endif

endmodule
`default_nettype wire

FILE: tb/tb_top.sv
// Testbench for the normalized 3x3 convolution unit: directed and random frames checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
  import ncv_pkg::*;

  localparam int K        = KERNEL_SIZE_DEFAULT;
  localparam int HALF     = K / 2;
  localparam int TAPS     = K * K;
  localparam int RING     = 2 * K;
  localparam int LINE_MAX = MAX_LINE_DEFAULT;
  localparam int SETTLE   = TAPS + 7 + 24;

  typedef struct {
    logic [PIX_W-1:0] pix;
    logic             last;
  } conv_result_t;

  class conv_scoreboard;
    int               coef_tab[TAPS];
    byte unsigned     line_ring[RING * LINE_MAX];
    int unsigned      in_row, in_col, out_row, out_col;
    logic [SIZE_W-1:0] len_reg, cnt_reg;
    longint           recip;
    conv_result_t     pending_q[$];
    int               mismatches, results, lasts;

    function new();
      foreach (coef_tab[i]) coef_tab[i] = 0;
      foreach (line_ring[i]) line_ring[i] = 0;
      restart();
      len_reg = 11'd1024;
      cnt_reg = 11'd1024;
      recip = 65536;
      mismatches = 0;
      results = 0;
      lasts = 0;
    endfunction

    function void restart();
      in_row = 0;
      in_col = 0;
      out_row = 0;
      out_col = 0;
    endfunction

    function int unsigned eff_len();
      if (len_reg == 0) return 1;
      if (len_reg > LINE_MAX) return LINE_MAX;
      return len_reg;
    endfunction

    function int unsigned eff_cnt();
      return (cnt_reg == 0) ? 1 : cnt_reg;
    endfunction

    function bit frame_full();
      return in_row >= eff_cnt();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
      if (idx == REG_LINE_LENGTH) begin
        len_reg = d[SIZE_W-1:0];
        restart();
      end else if (idx == REG_LINE_COUNT) begin
        cnt_reg = d[SIZE_W-1:0];
        restart();
      end else if (idx == REG_NORM_RECIP) begin
        recip = longint'($signed(d));
      end
    endfunction

    function void produce_pixel();
      longint       acc, prod, v;
      int           r, c, dr, dc;
      int unsigned  len, cnt;
      conv_result_t res;
      len = eff_len();
      cnt = eff_cnt();
      acc = 0;
      for (dr = 0; dr < K; dr++) begin
        for (dc = 0; dc < K; dc++) begin
          r = int'(out_row) + dr - HALF;
          c = int'(out_col) + dc - HALF;
          if (r >= 0 && r < int'(cnt) && c >= 0 && c < int'(len))
            acc += longint'(line_ring[(r % RING) * LINE_MAX + c]) * coef_tab[dr * K + dc];
        end
      end
      prod = acc * recip;
      v = (prod < 0) ? 0 : (prod >>> FRAC_BITS);
      if (v > PIX_MAX) v = PIX_MAX;
      res.pix = v[PIX_W-1:0];
      res.last = (out_row + 1 >= cnt) && (out_col + 1 >= len);
      pending_q.push_back(res);
      if (res.last) begin
        restart();
      end else begin
        out_col++;
        if (out_col >= len) begin
          out_col = 0;
          out_row++;
        end
      end
    endfunction

    function void filter_word(logic [OP_W-1:0] o, logic [PIX_W-1:0] p,
                              logic [COEF_IDX_W-1:0] idx, logic signed [COEF_W-1:0] val);
      int unsigned len, cnt;
      longint      done_in, done_out;
      len = eff_len();
      cnt = eff_cnt();
      if (o == OP_COEF) begin
        if (idx < TAPS) coef_tab[idx] = int'(val);
      end else if (o == OP_PIXEL) begin
        if (in_row < cnt) begin
          line_ring[(in_row % RING) * LINE_MAX + in_col] = p;
          in_col++;
          if (in_col >= len) begin
            in_col = 0;
            in_row++;
          end
          done_in = longint'(in_row) * len + in_col;
          done_out = longint'(out_row) * len + out_col;
          if (done_out + HALF * len + HALF < done_in) produce_pixel();
        end
      end else if (o == OP_FLUSH) begin
        if (in_row >= cnt) produce_pixel();
      end
    endfunction

    function void check_pixel(logic [PIX_W-1:0] p, logic l);
      conv_result_t e;
      results++;
      if (l) lasts++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: pixel %0d last %0b", p, l);
        return;
      end
      e = pending_q.pop_front();
      if (e.pix !== p || e.last !== l) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected pixel %0d last %0b, got pixel %0d last %0b",
                   e.pix, e.last, p, l);
      end
    endfunction
  endclass

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic        [OP_W-1:0]       op = OP_COEF;
  logic        [PIX_W-1:0]      pixel_in = '0;
  logic        [COEF_IDX_W-1:0] coef_index = '0;
  logic signed [COEF_W-1:0]     coef_value = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic        [PIX_W-1:0]      pixel_out;
  logic                         out_last;
  logic                         cfg_we = 1'b0;
  logic        [CFG_IDX_W-1:0]  cfg_index = '0;
  logic        [CFG_DATA_W-1:0] cfg_data = '0;

  conv_scoreboard sb = new();
  int burst_left = 0;
  int words_sent = 0;
  int frames_done = 0;
  int hold_cnt = 0;
  bit held_once = 1'b0;
  int unsigned rx_cyc = 0;

  always #1 clk = ~clk;

  normalized_2d_convolution_unit DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .pixel_in(pixel_in), .coef_index(coef_index), .coef_value(coef_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .pixel_out(pixel_out), .out_last(out_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1;
    if (!rst && out_valid && out_ready) sb.check_pixel(pixel_out, out_last);
    if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      out_ready <= 1'b0;
    end else if (!held_once && sb.results >= 150) begin
      held_once <= 1'b1;
      hold_cnt <= 400;
      out_ready <= 1'b0;
    end else begin
      case (rx_cyc[7:6])
        2'd0: out_ready <= 1'b1;
        2'd3: out_ready <= $urandom_range(0, 1);
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  task automatic send_word(logic [OP_W-1:0] o, logic [PIX_W-1:0] p,
                           logic [COEF_IDX_W-1:0] idx, logic signed [COEF_W-1:0] val);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 48);
    end
    in_valid <= 1'b1;
    op <= o;
    pixel_in <= p;
    coef_index <= idx;
    coef_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.filter_word(o, p, idx, val);
    burst_left--;
    words_sent++;
  endtask

  task automatic go_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
    cfg_we <= 1'b0;
  endtask

  task automatic send_noise();
    case ($urandom_range(0, 3))
      0: send_word(2'd3, $urandom, $urandom, $urandom);
      1: send_word(OP_COEF, $urandom, $urandom_range(TAPS, 15), $urandom);
      2: send_word(OP_FLUSH, $urandom, $urandom, $urandom);
      default: send_word(OP_COEF, $urandom, $urandom_range(0, TAPS - 1), $urandom);
    endcase
  endtask

  task automatic run_frame(bit noisy, bit cut_short);
    int total;
    total = sb.eff_len() * sb.eff_cnt();
    if (cut_short) total = total / 2;
    for (int i = 0; i < total; i++) begin
      if (noisy && $urandom_range(0, 19) == 0) send_noise();
      send_word(OP_PIXEL, $urandom, $urandom, $urandom);
    end
    if (cut_short) return;
    while (sb.frame_full()) begin
      if (noisy && $urandom_range(0, 14) == 0)
        send_word(OP_PIXEL, $urandom, $urandom, $urandom);
      send_word(OP_FLUSH, $urandom, $urandom, $urandom);
    end
    frames_done++;
  endtask

  task automatic load_kernel(bit tame);
    for (int i = 0; i < TAPS; i++)
      send_word(OP_COEF, $urandom, i, tame ? $urandom_range(0, 10240) - 2048 : $urandom);
  endtask

  initial begin
    int n;
    bit tame;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_LINE_LENGTH, 32'd3);
    write_reg(REG_LINE_COUNT, 32'd2);
    write_reg(REG_NORM_RECIP, 32'd65536);
    send_word(OP_FLUSH, 8'hff, 4'hf, 18'h3ffff);
    send_word(2'd3, 8'hff, 4'hf, 18'h3ffff);
    send_word(OP_COEF, 8'h00, 4'd15, 18'sh1ffff);
    send_word(OP_COEF, 8'h00, 4'd0, 18'sh1ffff);
    send_word(OP_COEF, 8'h00, 4'd4, -18'sd131072);
    send_word(OP_COEF, 8'h00, 4'd8, 18'sd4096);
    send_word(OP_PIXEL, 8'd255, 4'd0, 18'sd0);
    send_word(OP_PIXEL, 8'd0, 4'd0, 18'sd0);
    send_word(OP_PIXEL, 8'd255, 4'd0, 18'sd0);
    send_word(OP_PIXEL, 8'd128, 4'd0, 18'sd0);
    send_word(OP_COEF, 8'h00, 4'd4, 18'sd4096);
    send_word(OP_PIXEL, 8'd1, 4'd0, 18'sd0);
    send_word(OP_PIXEL, 8'd254, 4'd0, 18'sd0);
    send_word(OP_PIXEL, 8'd7, 4'd0, 18'sd0);
    while (sb.frame_full()) send_word(OP_FLUSH, 8'h00, 4'd0, 18'sd0);
    frames_done++;

    while (words_sent < 1300) begin
      go_idle();
      n = $urandom_range(0, 9);
      write_reg(REG_LINE_LENGTH, {$urandom} & 32'hffff_f800 |
                (n == 0 ? 32'd0 : $urandom_range(1, 12)));
      n = $urandom_range(0, 9);
      write_reg(REG_LINE_COUNT, {$urandom} & 32'hffff_f800 |
                (n == 0 ? 32'd0 : $urandom_range(1, 6)));
      n = $urandom_range(0, 9);
      tame = (n >= 3);
      case (n)
        0: write_reg(REG_NORM_RECIP, 32'h8000_0000);
        1: write_reg(REG_NORM_RECIP, 32'h7fff_ffff);
        2: write_reg(REG_NORM_RECIP, $urandom);
        default: write_reg(REG_NORM_RECIP, $urandom_range(500, 40000));
      endcase
      load_kernel(tame);
      run_frame($urandom_range(0, 3) == 0, $urandom_range(0, 11) == 0);
    end

    go_idle();
    write_reg(REG_LINE_LENGTH, 32'd2047);
    write_reg(REG_LINE_COUNT, 32'd1);
    write_reg(REG_NORM_RECIP, 32'd3000);
    load_kernel(1'b1);
    run_frame(1'b0, 1'b1);
    go_idle();
    write_reg(REG_LINE_LENGTH, 32'd1);
    write_reg(REG_LINE_COUNT, 32'd64);
    run_frame(1'b0, 1'b0);

    in_valid <= 1'b0;
    n = 0;
    while (sb.pending_q.size() != 0 && n < 100000) begin
      @(posedge clk);
      n++;
    end
    repeat (SETTLE) @(posedge clk);
    if (sb.pending_q.size() != 0) begin
      $display("%0d expected pixels never arrived", sb.pending_q.size());
      sb.mismatches += sb.pending_q.size();
    end
    $display("Sent %0d words over %0d complete frames; checked %0d output pixels, %0d frame ends.",
             words_sent, frames_done, sb.results, sb.lasts);
    $display("Mismatches: %0d.", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: failure");
    $finish;
  end

endmodule
